// ===== rtl/core/cmr_pkg.sv =====
// Shared constants for the CAN multi-frame reassembler.
`timescale 1ns / 1ps

package cmr_pkg;

  localparam int unsigned MSG_BYTES = 198;

  localparam logic [10:0] ID_FIRST  = 11'h431;
  localparam logic [10:0] ID_MIDDLE = 11'h432;
  localparam logic [10:0] ID_TAIL   = 11'h433;

  localparam logic [7:0] MODE_TEST   = 8'h1B;
  localparam logic [7:0] MODE_NORMAL = 8'h1A;

  localparam logic [2:0] ST_IGNORED  = 3'd0;
  localparam logic [2:0] ST_STORED   = 3'd1;
  localparam logic [2:0] ST_COMPLETE = 3'd2;
  localparam logic [2:0] ST_HALTED   = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;

  // byte counts of each frame kind
  localparam logic [2:0] CNT_FIRST       = 3'd5;
  localparam logic [2:0] CNT_MIDDLE      = 3'd7;
  localparam logic [2:0] CNT_TAIL_TEST   = 3'd3;
  localparam logic [2:0] CNT_TAIL_NORMAL = 3'd4;

  // the store is split into byte lanes by address bits [2:0]
  localparam int unsigned LANES     = 8;
  localparam int unsigned LANE_BITS = 3;

endpackage

// ===== rtl/core/cmr_if.sv =====
// Valid/ready channel interfaces for reassembler items and results.
`timescale 1ns / 1ps

interface cmr_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [10:0] frame_id;
  logic [7:0]  byte1;
  logic [7:0]  byte2;
  logic [7:0]  byte3;
  logic [7:0]  byte4;
  logic [7:0]  byte5;
  logic [7:0]  byte6;
  logic [7:0]  byte7;
  logic [7:0]  read_addr;

  modport source (
    output valid, cmd, frame_id, byte1, byte2, byte3, byte4, byte5, byte6, byte7, read_addr,
    input  ready
  );
  modport sink (
    input  valid, cmd, frame_id, byte1, byte2, byte3, byte4, byte5, byte6, byte7, read_addr,
    output ready
  );
endinterface

interface cmr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] fill_length;
  logic       test_mode;
  logic [7:0] read_byte;

  modport source (
    output valid, status, fill_length, test_mode, read_byte,
    input  ready
  );
  modport sink (
    input  valid, status, fill_length, test_mode, read_byte,
    output ready
  );
endinterface

// ===== rtl/core/cmr_ram.sv =====
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps

module cmr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/can_multiframe_reassembler.sv =====
// CAN multi-frame telemetry reassembler: top level.
//
// Input channel in_i carries one word per received CAN frame (cmd 0) or per
// read of a stored message byte (cmd 1). Output channel out_o returns exactly
// one result word per input word, in order: status, fill length, mode and,
// for reads, the byte at read_addr (zero at or beyond the fill length).
// A word is taken every cycle when out_o is not stalled; an accepted word
// passes through stage 1 (state update plus lane RAM read), then the output
// register, which drives out_o.valid.
// The message store is eight byte-wide lane RAMs addressed by byte position
// modulo 8, so a frame's up to seven bytes land in the same cycle, one per lane.
// A first frame restarts the fill; positions below the fill are always
// written, so the store needs no clearing pass after reset or first frame.
// Reset clears fill, mode and the sticky overflow halt, and empties both
// pipeline registers. When out_o.ready is low the output word holds and the
// block keeps accepting until its one internal stage is also full.
`timescale 1ns / 1ps

module can_multiframe_reassembler #(
  parameter int unsigned MsgBytes = cmr_pkg::MSG_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cmr_in_if.sink     in_i,
  cmr_out_if.source  out_o
);

  localparam int unsigned Rows    = (MsgBytes + cmr_pkg::LANES - 1) / cmr_pkg::LANES;
  localparam int unsigned RowBits = (Rows > 1) ? $clog2(Rows) : 1;
  localparam logic [7:0]  MidLimit  = 8'(MsgBytes - 7);
  localparam logic [7:0]  TailLimit = 8'(MsgBytes - 4);
  localparam logic [8:0]  MsgEnd    = 9'(MsgBytes);

  // handshake
  logic in_acc;
  logic in_ready;
  logic s1_adv;

  // architectural state
  logic [7:0] fill_q, fill_d;
  logic       test_q, test_d;
  logic       halt_q, halt_d;

  // per-word decode
  logic [2:0] status_d;
  logic       rd_hit_d;
  logic       wr_en;
  logic [7:0] wr_base;
  logic [2:0] wr_cnt;
  logic       src_skip;

  logic [7:0] frame_b [7];
  logic [7:0] src_b   [cmr_pkg::LANES];

  // lane RAM ports
  logic               lane_we    [cmr_pkg::LANES];
  logic [RowBits-1:0] lane_waddr [cmr_pkg::LANES];
  logic [7:0]         lane_wdata [cmr_pkg::LANES];
  logic [7:0]         lane_q     [cmr_pkg::LANES];
  logic               rd_en;

  // stage 1 (RAM read in flight) and output register
  logic                          s1_valid_q;
  logic [2:0]                    s1_status_q;
  logic [7:0]                    s1_fill_q;
  logic                          s1_test_q;
  logic                          s1_hit_q;
  logic [cmr_pkg::LANE_BITS-1:0] s1_lane_q;

  logic       out_valid_q;
  logic [2:0] out_status_q;
  logic [7:0] out_fill_q;
  logic       out_test_q;
  logic [7:0] out_byte_q;

  assign s1_adv   = !out_valid_q || out_o.ready;
  assign in_ready = !s1_valid_q || s1_adv;
  assign in_acc   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  assign frame_b = '{in_i.byte1, in_i.byte2, in_i.byte3, in_i.byte4,
                     in_i.byte5, in_i.byte6, in_i.byte7};

  always_comb begin
    fill_d   = fill_q;
    test_d   = test_q;
    halt_d   = halt_q;
    status_d = cmr_pkg::ST_IGNORED;
    rd_hit_d = 1'b0;
    wr_en    = 1'b0;
    wr_base  = fill_q;
    wr_cnt   = 3'd0;
    src_skip = 1'b0;

    if (in_i.cmd) begin
      status_d = cmr_pkg::ST_READ;
      rd_hit_d = ({1'b0, in_i.read_addr} < MsgEnd) && (in_i.read_addr < fill_q);
    end else if (halt_q) begin
      status_d = cmr_pkg::ST_HALTED;
    end else begin
      case (in_i.frame_id)
        cmr_pkg::ID_FIRST: begin
          if (in_i.byte2 == cmr_pkg::MODE_TEST) begin
            test_d = 1'b1;
          end else if (in_i.byte2 == cmr_pkg::MODE_NORMAL) begin
            test_d = 1'b0;
          end
          wr_en    = 1'b1;
          wr_base  = 8'd0;
          wr_cnt   = cmr_pkg::CNT_FIRST;
          src_skip = 1'b1;
          status_d = cmr_pkg::ST_STORED;
        end
        cmr_pkg::ID_MIDDLE: begin
          if (fill_q > MidLimit) begin
            halt_d   = 1'b1;
            status_d = cmr_pkg::ST_HALTED;
          end else begin
            wr_en    = 1'b1;
            wr_cnt   = cmr_pkg::CNT_MIDDLE;
            status_d = cmr_pkg::ST_STORED;
          end
        end
        cmr_pkg::ID_TAIL: begin
          if (fill_q > TailLimit) begin
            halt_d   = 1'b1;
            status_d = cmr_pkg::ST_HALTED;
          end else begin
            wr_en    = 1'b1;
            wr_cnt   = test_q ? cmr_pkg::CNT_TAIL_TEST : cmr_pkg::CNT_TAIL_NORMAL;
            status_d = cmr_pkg::ST_COMPLETE;
          end
        end
        default: status_d = cmr_pkg::ST_IGNORED;
      endcase
    end

    if (wr_en) begin
      fill_d = wr_base + {5'd0, wr_cnt};
    end
  end

  // first frames carry data from byte 3 onwards
  for (genvar k = 0; k < cmr_pkg::LANES; k++) begin : g_src
    if (k < 5) begin : g_both
      assign src_b[k] = src_skip ? frame_b[k+2] : frame_b[k];
    end else if (k < 7) begin : g_plain
      assign src_b[k] = src_skip ? 8'd0 : frame_b[k];
    end else begin : g_none
      assign src_b[k] = 8'd0;
    end
  end

  assign rd_en = in_acc && in_i.cmd;

  for (genvar b = 0; b < cmr_pkg::LANES; b++) begin : g_lane
    logic [cmr_pkg::LANE_BITS-1:0] ofs;
    logic [8:0]                    pos;

    // which byte of this word falls into lane b
    assign ofs = cmr_pkg::LANE_BITS'(b) - wr_base[cmr_pkg::LANE_BITS-1:0];
    assign pos = {1'b0, wr_base} + {6'd0, ofs};

    assign lane_we[b]    = in_acc && wr_en && (ofs < wr_cnt) && (pos < MsgEnd);
    assign lane_waddr[b] = pos[cmr_pkg::LANE_BITS +: RowBits];
    assign lane_wdata[b] = src_b[ofs];

    cmr_ram #(
      .Width (8),
      .Depth (Rows)
    ) u_lane_ram (
      .clk_i   (clk_i),
      .we_i    (lane_we[b]),
      .waddr_i (lane_waddr[b]),
      .wdata_i (lane_wdata[b]),
      .re_i    (rd_en),
      .raddr_i (in_i.read_addr[cmr_pkg::LANE_BITS +: RowBits]),
      .rdata_o (lane_q[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= 8'd0;
      test_q      <= 1'b0;
      halt_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        fill_q <= fill_d;
        test_q <= test_d;
        halt_q <= halt_d;
      end
      if (in_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_status_q <= status_d;
      s1_fill_q   <= fill_d;
      s1_test_q   <= test_d;
      s1_hit_q    <= rd_hit_d;
      s1_lane_q   <= in_i.read_addr[cmr_pkg::LANE_BITS-1:0];
    end
    if (s1_adv && s1_valid_q) begin
      out_status_q <= s1_status_q;
      out_fill_q   <= s1_fill_q;
      out_test_q   <= s1_test_q;
      out_byte_q   <= s1_hit_q ? lane_q[s1_lane_q] : 8'd0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.fill_length = out_fill_q;
  assign out_o.test_mode   = out_test_q;
  assign out_o.read_byte   = out_byte_q;

endmodule

// ===== rtl/core/cmr_checker.sv =====
// Port-level assertions for the reassembler, bound to the top level.
`timescale 1ns / 1ps

module cmr_checker #(
  parameter int unsigned MsgBytes = cmr_pkg::MSG_BYTES
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_status_i,
  input logic [7:0] out_fill_length_i,
  input logic [7:0] out_read_byte_i
);

  logic halt_seen_q;

  // an overflow halt once delivered stays until reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halt_seen_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && out_status_i == cmr_pkg::ST_HALTED) begin
      halt_seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_fill_length_i) && $stable(out_read_byte_i))
    else $error("result word changed while stalled");

  a_byte_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != cmr_pkg::ST_READ |-> out_read_byte_i == 8'd0)
    else $error("read byte non-zero on a frame result");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && halt_seen_q && out_status_i != cmr_pkg::ST_READ
      |-> out_status_i == cmr_pkg::ST_HALTED)
    else $error("frame handled after overflow halt");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_fill_length_i <= 8'(MsgBytes) && out_status_i <= cmr_pkg::ST_READ)
    else $error("fill length or status out of range");

endmodule

bind can_multiframe_reassembler cmr_checker #(
  .MsgBytes (MsgBytes)
) u_cmr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_status_i      (out_o.status),
  .out_fill_length_i (out_o.fill_length),
  .out_read_byte_i   (out_o.read_byte)
);

// ===== tb/cmr_reassembly_checker.sv =====
// Scoreboard for the reassembler: predicts every result word and compares it.
`timescale 1ns / 1ps

module cmr_reassembly_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cmr_in_if           in_mon_i,
  cmr_out_if          out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned completes_o
);
  import cmr_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] fill_length;
    logic       test_mode;
    logic [7:0] read_byte;
  } result_t;

  result_t    expected_q[$];
  result_t    got_r;
  result_t    exp_r;
  logic [7:0] msg_store [MSG_BYTES];
  logic [7:0] fill_pos;
  logic       test_flag;
  logic       halted;

  // data[0] is frame byte 1
  function automatic void store_bytes(input logic [6:0][7:0] data, input int unsigned first,
                                      input int unsigned count);
    int unsigned pos;
    for (int unsigned k = 0; k < count; k++) begin
      pos = 32'(fill_pos) + k;
      if (pos < MSG_BYTES) msg_store[pos] = data[first + k];
    end
    fill_pos = fill_pos + 8'(count);
  endfunction

  function automatic result_t reassemble(input logic cmd, input logic [10:0] id,
                                         input logic [6:0][7:0] data, input logic [7:0] addr);
    result_t r;
    r = '0;
    if (cmd) begin
      if (32'(addr) < 32'(fill_pos) && 32'(addr) < MSG_BYTES) r.read_byte = msg_store[addr];
      r.status = ST_READ;
    end else if (halted) begin
      r.status = ST_HALTED;
    end else if (id == ID_FIRST) begin
      if (data[1] == MODE_TEST) test_flag = 1'b1;
      else if (data[1] == MODE_NORMAL) test_flag = 1'b0;
      foreach (msg_store[i]) msg_store[i] = 8'h00;
      fill_pos = 8'h00;
      store_bytes(data, 2, 32'(CNT_FIRST));
      r.status = ST_STORED;
    end else if (id == ID_MIDDLE) begin
      if (32'(fill_pos) > MSG_BYTES - 32'(CNT_MIDDLE)) begin
        halted = 1'b1;
        r.status = ST_HALTED;
      end else begin
        store_bytes(data, 0, 32'(CNT_MIDDLE));
        r.status = ST_STORED;
      end
    end else if (id == ID_TAIL) begin
      // room is checked for four bytes whatever the mode
      if (32'(fill_pos) > MSG_BYTES - 32'(CNT_TAIL_NORMAL)) begin
        halted = 1'b1;
        r.status = ST_HALTED;
      end else begin
        store_bytes(data, 0, test_flag ? 32'(CNT_TAIL_TEST) : 32'(CNT_TAIL_NORMAL));
        r.status = ST_COMPLETE;
      end
    end
    r.fill_length = fill_pos;
    r.test_mode   = test_flag;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input result_t want, input result_t seen);
    fail_count_o++;
    if (fail_count_o <= REPORT_LIMIT)
      $display({"%s: expected status %0d fill %0d mode %0d byte %02h,",
                " got status %0d fill %0d mode %0d byte %02h"},
               what, want.status, want.fill_length, want.test_mode, want.read_byte,
               seen.status, seen.fill_length, seen.test_mode, seen.read_byte);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      foreach (msg_store[i]) msg_store[i] = 8'h00;
      fill_pos     = 8'h00;
      test_flag    = 1'b0;
      halted       = 1'b0;
      fail_count_o = 0;
      pending_o    = 0;
      results_o    = 0;
      completes_o  = 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        got_r.status      = out_mon_i.status;
        got_r.fill_length = out_mon_i.fill_length;
        got_r.test_mode   = out_mon_i.test_mode;
        got_r.read_byte   = out_mon_i.read_byte;
        results_o++;
        if (got_r.status == ST_COMPLETE) completes_o++;
        if (expected_q.size() == 0) begin
          report_mismatch("result word with nothing outstanding", '0, got_r);
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r !== exp_r) report_mismatch("result word mismatch", exp_r, got_r);
        end
      end
      if (in_mon_i.valid && in_mon_i.ready)
        expected_q.push_back(reassemble(in_mon_i.cmd, in_mon_i.frame_id,
                                        {in_mon_i.byte7, in_mon_i.byte6, in_mon_i.byte5,
                                         in_mon_i.byte4, in_mon_i.byte3, in_mon_i.byte2,
                                         in_mon_i.byte1},
                                        in_mon_i.read_addr));
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== tb/can_multiframe_reassembler_test.sv =====
// Testbench top: clock, reset, frame and read stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module can_multiframe_reassembler_test;
  import cmr_pkg::*;

  localparam int unsigned CLK_HALF         = 10;
  localparam int unsigned WATCHDOG_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES      = 80;
  localparam int unsigned RANDOM_PER_PHASE = 85;
  localparam int unsigned TAIL_CYCLES      = 10;

  typedef struct packed {
    logic            cmd;
    logic [10:0]     frame_id;
    logic [6:0][7:0] data;
    logic [7:0]      read_addr;
  } can_word_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;
  int unsigned completes;
  int unsigned est_fill;
  int unsigned words_sent;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_reqs;
  int unsigned quiet_cycles = 0;
  string       halt_kind;

  cmr_in_if  frame_ch ();
  cmr_out_if result_ch ();

  can_multiframe_reassembler u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (frame_ch),
    .out_o  (result_ch)
  );

  cmr_reassembly_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (frame_ch),
    .out_mon_i    (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .completes_o  (completes)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_HALF);
    clk_i = 1'b1;
    #(CLK_HALF);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("can_multiframe_reassembler_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output side: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int unsigned holds_done;
    holds_done      = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holds_done++;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input can_word_t w);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    frame_ch.cmd       <= w.cmd;
    frame_ch.frame_id  <= w.frame_id;
    frame_ch.byte1     <= w.data[0];
    frame_ch.byte2     <= w.data[1];
    frame_ch.byte3     <= w.data[2];
    frame_ch.byte4     <= w.data[3];
    frame_ch.byte5     <= w.data[4];
    frame_ch.byte6     <= w.data[5];
    frame_ch.byte7     <= w.data[6];
    frame_ch.read_addr <= w.read_addr;
    frame_ch.valid     <= 1'b1;
    @(posedge clk_i);
    while (!frame_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
    // rough fill, never below the real one: tails counted as four bytes
    if (!w.cmd) begin
      case (w.frame_id)
        ID_FIRST:  est_fill = 32'(CNT_FIRST);
        ID_MIDDLE: est_fill += 32'(CNT_MIDDLE);
        ID_TAIL:   est_fill += 32'(CNT_TAIL_NORMAL);
        default:   ;
      endcase
    end
  endtask

  task automatic send_frame_bytes(input logic [10:0] id, input logic [6:0][7:0] data);
    can_word_t w;
    w.cmd       = 1'b0;
    w.frame_id  = id;
    w.data      = data;
    w.read_addr = 8'($urandom_range(255));
    send_word(w);
  endtask

  task automatic send_frame(input logic [10:0] id);
    logic [6:0][7:0] data;
    data = 56'({$urandom(), $urandom()});
    if (id == ID_FIRST) begin
      case ($urandom_range(3))
        0:       data[1] = MODE_TEST;
        1:       data[1] = MODE_NORMAL;
        default: ;
      endcase
    end
    send_frame_bytes(id, data);
  endtask

  task automatic send_read(input logic [7:0] addr);
    can_word_t w;
    w.cmd       = 1'b1;
    w.frame_id  = 11'($urandom_range(2047));
    w.data      = 56'({$urandom(), $urandom()});
    w.read_addr = addr;
    send_word(w);
  endtask

  function automatic bit frame_safe(input logic [10:0] id);
    return !((id == ID_MIDDLE && est_fill > MSG_BYTES - 32'(CNT_MIDDLE)) ||
             (id == ID_TAIL && est_fill > MSG_BYTES - 32'(CNT_TAIL_NORMAL)));
  endfunction

  initial begin
    int unsigned counted;
    int unsigned n_mid;
    int unsigned n_rd;
    int unsigned sel;
    logic [10:0] id;

    rst_ni             = 1'b0;
    frame_ch.valid     = 1'b0;
    frame_ch.cmd       = 1'b0;
    frame_ch.frame_id  = '0;
    frame_ch.byte1     = '0;
    frame_ch.byte2     = '0;
    frame_ch.byte3     = '0;
    frame_ch.byte4     = '0;
    frame_ch.byte5     = '0;
    frame_ch.byte6     = '0;
    frame_ch.byte7     = '0;
    frame_ch.read_addr = '0;
    idle_pct           = 0;
    stall_pct          = 0;
    hold_reqs          = 0;
    est_fill           = 0;
    words_sent         = 0;
    halt_kind          = "";

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed words
    send_read(8'd0);
    send_frame_bytes(ID_MIDDLE, {7{8'hFF}});   // appended with no first frame yet
    send_frame_bytes(ID_TAIL, {7{8'h00}});
    send_read(8'd6);
    send_read(8'd255);                         // beyond the store
    send_frame_bytes(11'h000, {7{8'hFF}});
    send_frame_bytes(11'h7FF, {7{8'hFF}});
    send_frame_bytes(ID_FIRST - 11'd1, {7{8'h00}});
    send_frame_bytes(ID_TAIL + 11'd1, {7{8'h00}});
    send_frame_bytes(ID_FIRST, {8'h77, 8'h66, 8'h55, 8'h44, 8'h33, MODE_TEST, 8'h11});
    send_read(8'd4);
    send_read(8'd10);                          // old bytes gone after the first frame
    send_frame(ID_MIDDLE);
    send_frame(ID_TAIL);                       // three-byte tail
    // unknown mode code keeps test mode
    send_frame_bytes(ID_FIRST, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h55, 8'h00});
    send_frame_bytes(ID_FIRST, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, MODE_NORMAL, 8'hFF});
    send_frame(ID_TAIL);
    send_read(8'd8);
    send_read(8'd9);                           // exactly at the fill
    send_read(8'd197);

    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 84; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      // long output hold while words keep coming, to back the block up
      if (phase == 0) hold_reqs++;
      counted = 0;
      while (counted < RANDOM_PER_PHASE) begin
        if ($urandom_range(99) < 65) begin
          send_frame(ID_FIRST);
          n_mid = ($urandom_range(9) == 0) ? $urandom_range(27) : $urandom_range(5);
          repeat (n_mid) send_frame(ID_MIDDLE);
          send_frame(ID_TAIL);
          n_rd = $urandom_range(3);
          repeat (n_rd) send_read(8'($urandom_range(est_fill)));
          counted += n_mid + n_rd + 2;
        end else begin
          sel = $urandom_range(3);
          if (sel == 0) begin
            send_read(8'($urandom_range(255)));
            counted++;
          end else begin
            id = (sel == 1) ? 11'($urandom_range(2047)) : ((sel == 2) ? ID_MIDDLE : ID_TAIL);
            if (!frame_safe(id)) id = ID_FIRST;
            send_frame(id);
            counted++;
          end
        end
      end
    end

    // the halt is sticky until reset, so it comes last: fill to 194 and overflow
    send_frame(ID_FIRST);
    repeat (27) send_frame(ID_MIDDLE);
    if ($urandom_range(1) == 0) begin
      halt_kind = "middle";
      send_frame(ID_MIDDLE);
    end else begin
      halt_kind = "tail";
      send_frame(ID_TAIL);
      send_frame(ID_TAIL);
    end
    send_frame(ID_FIRST);
    send_frame(ID_MIDDLE);
    send_frame(ID_TAIL);
    send_frame(11'h123);
    send_read(8'd0);
    send_read(8'd193);
    send_read(8'd197);
    frame_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Sent %0d words (frames and reads) over four stall/idle mixes; %0d results checked.",
             words_sent, results);
    $display("%0d messages completed; overflow halt reached by a %s frame.", completes, halt_kind);
    if (fail_count == 0) begin
      $display("can_multiframe_reassembler_test OK");
    end else begin
      $display("can_multiframe_reassembler_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cmr_pkg.sv
rtl/core/cmr_if.sv
rtl/core/cmr_ram.sv
rtl/core/can_multiframe_reassembler.sv
rtl/core/cmr_checker.sv
tb/cmr_reassembly_checker.sv
tb/can_multiframe_reassembler_test.sv
